// File: src/gre_header_validator_macros.svh
// Assertion helpers for the GRE header validator.
`ifndef GRE_HEADER_VALIDATOR_MACROS_SVH
`define GRE_HEADER_VALIDATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GRE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gre header validator: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define GRE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gre header validator: next-cycle check failed");

`endif

// File: src/grehv_pkg.sv
`default_nettype none

package grehv_pkg;

    // Longest packet counted; bytes past this are ignored.
    localparam int unsigned MAX_PACKET_BYTES = 65535;
    localparam logic [15:0] MAX_POS = 16'(MAX_PACKET_BYTES);

    // Protocol type codes
    localparam logic [15:0] PROTO_IPV4   = 16'h0800;
    localparam logic [15:0] PROTO_PPP    = 16'h880B;
    localparam logic [15:0] PROTO_IPV6   = 16'h86DD;
    localparam logic [15:0] PROTO_VLAN   = 16'h8100;
    localparam logic [15:0] PROTO_ERSPAN = 16'h88BE;
    localparam logic [15:0] PROTO_ETH    = 16'h6558;

    // Version field values
    localparam logic [2:0] GRE_V0 = 3'd0;
    localparam logic [2:0] GRE_V1 = 3'd1;

    // Verdict status; ST_TUNNEL also stands for "no early error"
    typedef enum logic [3:0] {
        ST_TUNNEL        = 4'd0,
        ST_TOO_SMALL     = 4'd1,
        ST_V0_RECUR      = 4'd2,
        ST_V0_FLAGS      = 4'd3,
        ST_V0_HDR_BIG    = 4'd4,
        ST_V0_BAD_SRE    = 4'd5,
        ST_V1_CHECKSUM   = 4'd6,
        ST_V1_ROUTE      = 4'd7,
        ST_V1_SSR        = 4'd8,
        ST_V1_RECUR      = 4'd9,
        ST_V1_FLAGS      = 4'd10,
        ST_V1_WRONG_PROTO= 4'd11,
        ST_V1_NO_KEY     = 4'd12,
        ST_V1_HDR_BIG    = 4'd13,
        ST_WRONG_VER     = 4'd14,
        ST_NO_TUNNEL     = 4'd15
    } status_t;

    typedef enum logic [2:0] {
        KIND_NONE      = 3'd0,
        KIND_IPV4      = 3'd1,
        KIND_PPP       = 3'd2,
        KIND_IPV6      = 3'd3,
        KIND_VLAN      = 3'd4,
        KIND_ERSPAN_I  = 3'd5,
        KIND_ERSPAN_II = 3'd6,
        KIND_ETH       = 3'd7
    } kind_t;

    // Per-packet parse state
    typedef struct packed {
        logic [15:0] pos;
        logic [7:0]  flags;
        logic [7:0]  verb;
        logic [15:0] proto;
        logic [15:0] pplen;
        logic [16:0] need;
        logic [16:0] sstart;
        logic [15:0] sfam;
        logic        done;
        status_t     err;
    } hs_t;

    localparam hs_t HS_RESET = '{
        pos: 16'd0, flags: 8'd0, verb: 8'd0, proto: 16'd0, pplen: 16'd0,
        need: 17'd4, sstart: 17'd0, sfam: 16'd0, done: 1'b0, err: ST_TUNNEL
    };

    typedef struct packed {
        status_t     status;
        kind_t       kind;
        logic [15:0] hlen;
        logic [15:0] plen;
    } verdict_t;

endpackage

`default_nettype wire

// File: src/grehv_verdict.sv
`default_nettype none

module grehv_verdict import grehv_pkg::*; (
    input  hs_t      hs,
    output verdict_t vd
);

    logic [15:0] len;
    logic [2:0]  ver;
    logic [16:0] hlen;
    logic [15:0] plen_raw;
    status_t     st;
    kind_t       kind;

    assign len = hs.pos;
    assign ver = hs.verb[2:0];
    assign plen_raw = len - hs.need[15:0];

    // Pick the verdict in priority order
    always_comb begin
        st   = ST_TUNNEL;
        kind = KIND_NONE;
        hlen = 17'd4;
        priority if (len < 16'd4) begin
            st = ST_TOO_SMALL;
        end else if (hs.err != ST_TUNNEL) begin
            st = hs.err;
        end else if (hs.need > {1'b0, len} && !(ver == GRE_V0 && hs.done)) begin
            hlen = hs.need;
            st   = (ver == GRE_V0) ? ST_V0_HDR_BIG : ST_V1_HDR_BIG;
        end else if (ver == GRE_V0 && hs.flags[6] && !hs.done) begin
            hlen = hs.sstart;
            st   = ST_V0_BAD_SRE;
        end else begin
            hlen = hs.need;
            // Map protocol type to inner kind
            unique case (hs.proto)
                PROTO_IPV4: kind = KIND_IPV4;
                PROTO_PPP: begin
                    if (ver == GRE_V1 && hs.pplen == 16'd0) begin
                        st = ST_NO_TUNNEL;
                    end else begin
                        kind = KIND_PPP;
                    end
                end
                PROTO_IPV6: kind = KIND_IPV6;
                PROTO_VLAN: kind = KIND_VLAN;
                PROTO_ERSPAN: kind = hs.flags[4] ? KIND_ERSPAN_II : KIND_ERSPAN_I;
                PROTO_ETH: kind = KIND_ETH;
                default: st = ST_NO_TUNNEL;
            endcase
        end
    end

    // Saturate header length, gate payload length on a tunnel verdict
    always_comb begin
        vd.status = st;
        vd.kind   = kind;
        vd.hlen   = hlen[16] ? 16'hFFFF : hlen[15:0];
        vd.plen   = (st == ST_TUNNEL) ? plen_raw : 16'd0;
    end

endmodule

`default_nettype wire

// File: src/gre_header_validator.sv
// GRE header validator.
// Input: one packet byte per beat on s_data_byte, s_last_byte high on the
// final beat of a packet, under s_valid/s_ready. Output: one verdict beat per
// packet (m_status, m_tunnel_kind, m_header_length, m_payload_length,
// m_gre_version, m_protocol_type) under m_valid/m_ready.
// Throughput: one byte per cycle unless a final byte stalls (see Stall), packets
// back to back with no gap. Each beat lands in an input register, then
// combinational parse logic updates the per-packet state; on the last byte the
// verdict is formed in the same cycle and loaded into the output register.
// Path: the last byte is held in the input register, then its verdict is loaded
// into the output register, which drives m_valid until m_ready takes it.
// Stall: while a verdict waits on m_ready, non-final bytes keep flowing; a
// final byte holds in the input register until the output register frees,
// and s_ready drops only then.
// Reset (aresetn low, synchronous): both registers empty, parse state back to
// start of packet. Bytes past 65535 in one packet are counted as not there.
`default_nettype none

`include "gre_header_validator_macros.svh"

module gre_header_validator import grehv_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_status,
    output logic [2:0]       m_tunnel_kind,
    output logic [15:0]      m_header_length,
    output logic [15:0]      m_payload_length,
    output logic [2:0]       m_gre_version,
    output logic [15:0]      m_protocol_type
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;
    logic        m_valid_reg, m_valid_next;
    logic        out_free, in_adv, emit;
    hs_t         hs_reg, hs_next, hs_upd;
    verdict_t    vd;
    status_t     status_reg;
    kind_t       kind_reg;
    logic [15:0] hlen_reg, plen_reg, proto_reg;
    logic [2:0]  ver_reg;

    logic        take;
    logic [7:0]  b;
    logic [1:0]  opt_cnt;
    logic [16:0] sre_off;

    // Handshake between stages
    assign out_free = !m_valid_reg || m_ready;
    assign in_adv   = in_valid_reg && (!in_last_reg || out_free);
    assign emit     = in_adv && in_last_reg;
    assign s_ready  = !in_valid_reg || in_adv;

    assign in_valid_next = (s_valid && s_ready) ? 1'b1 : (in_adv ? 1'b0 : in_valid_reg);
    assign m_valid_next  = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    assign take    = hs_reg.pos != MAX_POS;
    assign b       = in_data_reg;
    assign opt_cnt = {1'b0, hs_reg.flags[5]} + {1'b0, hs_reg.flags[4]}
                   + {1'b0, hs_reg.flags[7] | hs_reg.flags[6]};
    assign sre_off = {1'b0, hs_reg.pos} - hs_reg.sstart;

    // Fold the current byte into the parse state
    always_comb begin
        hs_upd = hs_reg;
        if (take) begin
            hs_upd.pos = hs_reg.pos + 16'd1;
            priority if (hs_reg.pos == 16'd0) begin
                hs_upd.flags = b;
            end else if (hs_reg.pos == 16'd1) begin
                hs_upd.verb = b;
                hs_upd.err  = ST_TUNNEL;
                if (b[2:0] == GRE_V0) begin
                    if (hs_reg.flags[2:0] != 3'd0) begin
                        hs_upd.err = ST_V0_RECUR;
                    end else if (b[6:3] != 4'd0) begin
                        hs_upd.err = ST_V0_FLAGS;
                    end
                    hs_upd.need   = 17'd4 + {13'd0, opt_cnt, 2'b00};
                    hs_upd.sstart = 17'd4 + {13'd0, opt_cnt, 2'b00};
                end else if (b[2:0] == GRE_V1) begin
                    priority if (hs_reg.flags[7]) begin
                        hs_upd.err = ST_V1_CHECKSUM;
                    end else if (hs_reg.flags[6]) begin
                        hs_upd.err = ST_V1_ROUTE;
                    end else if (hs_reg.flags[3]) begin
                        hs_upd.err = ST_V1_SSR;
                    end else if (hs_reg.flags[2:0] != 3'd0) begin
                        hs_upd.err = ST_V1_RECUR;
                    end else if (b[6:3] != 4'd0) begin
                        hs_upd.err = ST_V1_FLAGS;
                    end else begin
                        hs_upd.err = ST_TUNNEL;
                    end
                    hs_upd.need = 17'd8 + {14'd0, hs_reg.flags[4], 2'b00}
                                + {14'd0, b[7], 2'b00};
                end else begin
                    hs_upd.err  = ST_WRONG_VER;
                    hs_upd.need = 17'd4;
                end
            end else if (hs_reg.pos == 16'd2) begin
                hs_upd.proto = {b, 8'h00};
            end else if (hs_reg.pos == 16'd3) begin
                hs_upd.proto = {hs_reg.proto[15:8], b};
                if (hs_reg.err == ST_TUNNEL && hs_reg.verb[2:0] == GRE_V1) begin
                    if ({hs_reg.proto[15:8], b} != PROTO_PPP) begin
                        hs_upd.err = ST_V1_WRONG_PROTO;
                    end else if (!hs_reg.flags[5]) begin
                        hs_upd.err = ST_V1_NO_KEY;
                    end
                end
            end else begin
                if (hs_reg.pos == 16'd4) begin
                    hs_upd.pplen = {b, 8'h00};
                end else if (hs_reg.pos == 16'd5) begin
                    hs_upd.pplen = {hs_reg.pplen[15:8], b};
                end
                // Walk SRE entries of a version 0 routed header
                if (hs_reg.verb[2:0] == GRE_V0 && hs_reg.flags[6]
                    && hs_reg.err == ST_TUNNEL && !hs_reg.done
                    && {1'b0, hs_reg.pos} >= hs_reg.sstart) begin
                    if (sre_off == 17'd0) begin
                        hs_upd.sfam = {b, 8'h00};
                    end else if (sre_off == 17'd1) begin
                        hs_upd.sfam = {hs_reg.sfam[15:8], b};
                    end else if (sre_off == 17'd3) begin
                        if (hs_reg.sfam == 16'd0 && b == 8'd0) begin
                            hs_upd.done = 1'b1;
                            hs_upd.need = hs_reg.sstart + 17'd4;
                        end else begin
                            hs_upd.sstart = hs_reg.sstart + 17'd4 + {9'd0, b};
                        end
                    end
                end
            end
        end
    end

    grehv_verdict u_verdict (
        .hs (hs_upd),
        .vd (vd)
    );

    // Clear state at end of packet
    assign hs_next = in_last_reg ? HS_RESET : hs_upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hs_reg <= HS_RESET;
        end else if (in_adv) begin
            hs_reg <= hs_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (emit) begin
            status_reg <= vd.status;
            kind_reg   <= vd.kind;
            hlen_reg   <= vd.hlen;
            plen_reg   <= vd.plen;
            ver_reg    <= hs_upd.verb[2:0];
            proto_reg  <= hs_upd.proto;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = 4'(status_reg);
    assign m_tunnel_kind    = 3'(kind_reg);
    assign m_header_length  = hlen_reg;
    assign m_payload_length = plen_reg;
    assign m_gre_version    = ver_reg;
    assign m_protocol_type  = proto_reg;

    // Checks
    `GRE_ASSERT_IMP(a_kind_only_on_tunnel, aclk, aresetn, m_valid_reg && status_reg != ST_TUNNEL, kind_reg == KIND_NONE)
    `GRE_ASSERT_IMP(a_plen_only_on_tunnel, aclk, aresetn, m_valid_reg && status_reg != ST_TUNNEL, plen_reg == 16'd0)
    `GRE_ASSERT_IMP(a_short_hlen, aclk, aresetn, m_valid_reg && status_reg == ST_TOO_SMALL, hlen_reg == 16'd4)
    `GRE_ASSERT_NEXT(a_clear_after_last, aclk, aresetn, emit, hs_reg.pos == 16'd0 && m_valid_reg)

endmodule

`default_nettype wire
